>>> rtl/gkps_pkg.sv
// ----------------------------------------------------------------------------
// gkps_pkg
// Shared types and constants for the gapped k-mer position scorer.
// ----------------------------------------------------------------------------
package gkps_pkg;

    // default structure parameters
    localparam int HALF_K_DEF   = 4;
    localparam int MAX_GAP_DEF  = 8;
    localparam int POS_BITS_DEF = 32;

    // field widths
    localparam int OP_W     = 2;
    localparam int IDX_W    = 20;
    localparam int TSCORE_W = 32;
    localparam int BASE_W   = 3;
    localparam int POS_W    = 32;
    localparam int SCORE_W  = 40;

    // stream word widths
    localparam int S_TDATA_W = 56;   // index, table score, base, pad
    localparam int M_TDATA_W = 72;   // position, score

    // configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAP_MIN = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAP_MAX = 1'd1;
    localparam logic [CFG_DATA_W-1:0] GAP_MIN_RST = 4'd0;
    localparam logic [CFG_DATA_W-1:0] GAP_MAX_RST = 4'd8;

    // op codes carried in tuser
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_BASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    // base code used for empty history slots
    localparam logic [BASE_W-1:0] BASE_OTHER = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic tbl_write;   // table write from the input word
        logic clr_write;   // zero one table entry (post-reset sweep)
        logic base_shift;  // push base, bump count/fill, reload scan window
        logic pend_shift;  // shift pending sums toward slot 0
        logic scan_step;   // issue lookup for current gap, advance window
        logic step_clr;
        logic step_inc;
        logic emit_load;   // load output register from slot 0
        logic emit_last;
        logic seq_clear;   // drop all sequence state
    } gkps_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;    // sweep at final table entry
        logic scan_last;   // current gap is the last one to scan
        logic emit_ok;     // enough bases seen for a per-base emit
        logic flush_elig;  // current flush slot holds a real position
        logic flush_done;  // flush walked through every slot
        logic out_free;    // output register can take a word
    } gkps_sts_t;

endpackage

>>> rtl/gkps_ram.sv
// ----------------------------------------------------------------------------
// gkps_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gkps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/gkps_ctrl.sv
// ----------------------------------------------------------------------------
// gkps_ctrl
// Sequencer: table clear sweep, per-base gap scan, emit and flush walk.
// ----------------------------------------------------------------------------
module gkps_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [gkps_pkg::OP_W-1:0] s_op,
    input  gkps_pkg::gkps_sts_t      sts,
    output gkps_pkg::gkps_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_CLR_MEM,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT,
        ST_FL_SHIFT,
        ST_FL_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLR_MEM: begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_op)
                        gkps_pkg::OP_WRITE: begin
                            cmd.tbl_write = 1'b1;
                        end
                        gkps_pkg::OP_BASE: begin
                            cmd.base_shift = 1'b1;
                            cmd.pend_shift = 1'b1;
                            cmd.step_clr   = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        gkps_pkg::OP_FLUSH: begin
                            cmd.step_clr = 1'b1;
                            state_next   = ST_FL_SHIFT;
                        end
                        default: begin
                            // unused op: dropped
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                cmd.step_inc  = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last lookup lands in the pending sums this cycle
                cmd.step_clr = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (!sts.emit_ok) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.emit_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_FL_SHIFT: begin
                if (sts.flush_done) begin
                    cmd.seq_clear = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    cmd.pend_shift = 1'b1;
                    cmd.step_inc   = 1'b1;
                    state_next     = ST_FL_EMIT;
                end
            end
            ST_FL_EMIT: begin
                if (!sts.flush_elig) begin
                    state_next = ST_FL_SHIFT;
                end else if (sts.out_free) begin
                    cmd.emit_load = 1'b1;
                    cmd.emit_last = sts.flush_done;
                    state_next    = ST_FL_SHIFT;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR_MEM;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/gkps_dp.sv
// ----------------------------------------------------------------------------
// gkps_dp
// Datapath: score table, base history, scan window, pending sums, output reg.
// ----------------------------------------------------------------------------
module gkps_dp #(
    parameter int HALF_K   = gkps_pkg::HALF_K_DEF,
    parameter int MAX_GAP  = gkps_pkg::MAX_GAP_DEF,
    parameter int POS_BITS = gkps_pkg::POS_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  gkps_pkg::gkps_cmd_t                  cmd,
    output gkps_pkg::gkps_sts_t                  sts,
    input  logic [gkps_pkg::IDX_W-1:0]           in_index,
    input  logic [gkps_pkg::TSCORE_W-1:0]        in_score,
    input  logic [gkps_pkg::BASE_W-1:0]          in_base,
    input  logic                                 cfg_we,
    input  logic [gkps_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [gkps_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [gkps_pkg::POS_W-1:0]           out_position,
    output logic [gkps_pkg::SCORE_W-1:0]         out_score,
    output logic                                 out_last
);

    localparam int KLEN      = 2 * HALF_K;
    localparam int HALF_BITS = 2 * HALF_K;
    localparam int HIST      = KLEN + MAX_GAP;
    localparam int HMAX      = (MAX_GAP + 1) / 2;
    localparam int DELAY     = HALF_K + HMAX;
    localparam int TBL_DEPTH = (MAX_GAP + 1) * (1 << (4 * HALF_K));
    localparam int ADDR_W    = $clog2(TBL_DEPTH);
    localparam int FILL_W    = $clog2(HIST + 1);
    localparam int STEP_MAX  = (MAX_GAP > DELAY - 1) ? MAX_GAP : DELAY - 1;
    localparam int STEP_W    = (STEP_MAX > 0) ? $clog2(STEP_MAX + 1) : 1;
    localparam int SLOT_W    = (DELAY > 1) ? $clog2(DELAY) : 1;
    localparam int SW        = gkps_pkg::SCORE_W;
    localparam int TW        = gkps_pkg::TSCORE_W;

    localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

    // config
    logic [gkps_pkg::CFG_DATA_W-1:0] gap_min_reg;
    logic [gkps_pkg::CFG_DATA_W-1:0] gap_max_reg;

    // sequence state
    logic [gkps_pkg::BASE_W-1:0] hist_reg [HIST];
    logic [gkps_pkg::BASE_W-1:0] scan_reg [HIST];
    logic signed [SW-1:0]        pend_reg [DELAY];
    logic [POS_BITS-1:0]         count_reg;
    logic [FILL_W-1:0]           fill_reg;
    logic [STEP_W-1:0]           step_reg;
    logic [ADDR_W-1:0]           clr_cnt_reg;

    // lookup pipeline
    logic                rd_v_reg;
    logic [SLOT_W-1:0]   rd_slot_reg;
    logic [SLOT_W-1:0]   rd_slot_next;
    logic [TW-1:0]       ram_rdata;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [TW-1:0]       ram_wdata;
    logic [ADDR_W-1:0]   key;
    logic [HALF_BITS-1:0] left_code;
    logic [HALF_BITS-1:0] right_code;
    logic                 halves_bad;
    logic                 lookup_ok;
    logic                 idx_ok;
    int                   gmax_eff;

    // accumulate
    logic signed [SW-1:0] acc_old;
    logic signed [SW:0]   acc_sum;
    logic signed [SW-1:0] acc_sat;

    // output register
    logic                        out_valid_reg;
    logic [gkps_pkg::POS_W-1:0]  out_pos_reg;
    logic [SW-1:0]               out_score_reg;
    logic                        out_last_reg;
    logic [POS_BITS-1:0]         emit_pos;

    // ---------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_min_reg <= gkps_pkg::GAP_MIN_RST;
            gap_max_reg <= gkps_pkg::GAP_MAX_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                gkps_pkg::CFG_GAP_MIN: gap_min_reg <= cfg_wdata;
                gkps_pkg::CFG_GAP_MAX: gap_max_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign gmax_eff = (int'(gap_max_reg) > MAX_GAP) ? MAX_GAP : int'(gap_max_reg);

    // ---------------------------------------------------------------- table
    assign idx_ok    = ({12'd0, in_index} < 32'(TBL_DEPTH));
    assign ram_we    = cmd.clr_write | (cmd.tbl_write & idx_ok);
    assign ram_waddr = cmd.clr_write ? clr_cnt_reg : ADDR_W'(in_index);
    assign ram_wdata = cmd.clr_write ? '0 : in_score;

    gkps_ram #(
        .WIDTH (TW),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.scan_step),
        .raddr (key),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_write) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // ------------------------------------------------------ history and scan
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.seq_clear) begin
            for (int i = 0; i < HIST; i++) begin
                hist_reg[i] <= gkps_pkg::BASE_OTHER;
            end
        end else if (cmd.base_shift) begin
            hist_reg[0] <= in_base;
            for (int i = 1; i < HIST; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    // scan window: scan_reg[i] tracks history[i + gap] during a scan
    always_ff @(posedge aclk) begin
        if (cmd.base_shift) begin
            scan_reg[0] <= in_base;
            for (int i = 1; i < HIST; i++) begin
                scan_reg[i] <= hist_reg[i-1];
            end
        end else if (cmd.scan_step) begin
            for (int i = 0; i < HIST - 1; i++) begin
                scan_reg[i] <= scan_reg[i+1];
            end
            scan_reg[HIST-1] <= gkps_pkg::BASE_OTHER;
        end
    end

    // halves: first base most significant
    always_comb begin
        left_code  = '0;
        right_code = '0;
        halves_bad = 1'b0;
        for (int d = 0; d < HALF_K; d++) begin
            left_code[2*(HALF_K-1-d) +: 2]  = scan_reg[KLEN-1-d][1:0];
            right_code[2*(HALF_K-1-d) +: 2] = hist_reg[HALF_K-1-d][1:0];
            halves_bad = halves_bad | scan_reg[KLEN-1-d][2] | hist_reg[HALF_K-1-d][2];
        end
    end

    assign key = (ADDR_W'(step_reg) << (4 * HALF_K))
               | (ADDR_W'(left_code) << HALF_BITS)
               | ADDR_W'(right_code);

    assign lookup_ok = !halves_bad
                     && (int'(step_reg) >= int'(gap_min_reg))
                     && (int'(step_reg) <= gmax_eff)
                     && (int'(fill_reg) >= KLEN + int'(step_reg));

    // window center lands (len+1)/2 slots back from the newest position
    assign rd_slot_next = SLOT_W'(HMAX - ((int'(step_reg) + 1) >> 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg <= 1'b0;
        end else begin
            rd_v_reg <= cmd.scan_step & lookup_ok;
        end
        rd_slot_reg <= rd_slot_next;
    end

    // ------------------------------------------------------- counters, step
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.seq_clear) begin
            count_reg <= '0;
            fill_reg  <= '0;
        end else if (cmd.base_shift) begin
            count_reg <= count_reg + 1'b1;
            if (int'(fill_reg) < HIST) begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.step_clr) begin
            step_reg <= '0;
        end else if (cmd.step_inc) begin
            step_reg <= step_reg + 1'b1;
        end
    end

    // ---------------------------------------------------------- pending sums
    assign acc_old = pend_reg[rd_slot_reg];
    assign acc_sum = {acc_old[SW-1], acc_old}
                   + {{(SW + 1 - TW){ram_rdata[TW-1]}}, ram_rdata};

    always_comb begin
        if (acc_sum[SW] != acc_sum[SW-1]) begin
            acc_sat = acc_sum[SW] ? SUM_MIN : SUM_MAX;
        end else begin
            acc_sat = acc_sum[SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.seq_clear) begin
            for (int i = 0; i < DELAY; i++) begin
                pend_reg[i] <= '0;
            end
        end else if (cmd.pend_shift) begin
            for (int i = 0; i < DELAY - 1; i++) begin
                pend_reg[i] <= pend_reg[i+1];
            end
            pend_reg[DELAY-1] <= '0;
        end else if (rd_v_reg) begin
            pend_reg[rd_slot_reg] <= acc_sat;
        end
    end

    // ------------------------------------------------------- output register
    // slot 0 holds position count - DELAY + step
    assign emit_pos = count_reg - POS_BITS'(DELAY) + POS_BITS'(step_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.emit_load) begin
            out_pos_reg   <= gkps_pkg::POS_W'(emit_pos);
            out_score_reg <= pend_reg[0];
            out_last_reg  <= cmd.emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_position = out_pos_reg;
    assign out_score    = out_score_reg;
    assign out_last     = out_last_reg;

    // ---------------------------------------------------------------- status
    always_comb begin
        sts            = '0;
        sts.clr_last   = (clr_cnt_reg == ADDR_W'(TBL_DEPTH - 1));
        sts.scan_last  = (int'(step_reg) >= gmax_eff);
        sts.emit_ok    = (int'(fill_reg) >= DELAY);
        sts.flush_elig = (int'(step_reg)
                          + ((int'(fill_reg) < DELAY - 1) ? int'(fill_reg) : DELAY - 1))
                         >= DELAY;
        sts.flush_done = (int'(step_reg) == DELAY - 1);
        sts.out_free   = !out_valid_reg || out_ready;
    end

endmodule

>>> rtl/gapped_kmer_position_scorer.sv
// ----------------------------------------------------------------------------
// gapped_kmer_position_scorer
// Scores every position of a DNA stream with gapped k-mer table lookups.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per op in s_tuser. Table write loads a Q16.16 score
//   at a gapped k-mer key; base pushes one base code; end of sequence flushes.
//   m_ channel: one word per scored position (position, saturated 40-bit sum),
//   m_tlast on the final position of a flush.
//   cfg_ port: gap_min / gap_max, written while the block is idle.
// Sequencing:
//   Table write: taken back to back. Base: one table read per gap length
//   on the single table read port, gaps 0 to gmax walked in order, then a
//   drain state and an emit state that loads the word into the output reg.
//   Flush: walks the DELAY - 1 pending slots however many positions are
//   pending, DELAY = HALF_K + ceil(MAX_GAP / 2); one word per position.
// Reset:
//   Synchronous on aresetn low. The table is then zeroed one entry a cycle
//   (589824 entries at defaults) with s_tready low; config writes still land.
// Stalls:
//   The result sits in an output register; the sequencer waits only when it
//   has a new word to load and the register is still held by m_tready low.
// ----------------------------------------------------------------------------
module gapped_kmer_position_scorer #(
    parameter int HALF_K   = gkps_pkg::HALF_K_DEF,
    parameter int MAX_GAP  = gkps_pkg::MAX_GAP_DEF,
    parameter int POS_BITS = gkps_pkg::POS_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [19:0] table_index, [51:20] table_score, [54:52] base, [55] zero
    input  logic [gkps_pkg::S_TDATA_W-1:0]      s_tdata,
    // [1:0] op
    input  logic [gkps_pkg::OP_W-1:0]           s_tuser,
    // result words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] position, [71:32] score
    output logic [gkps_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [gkps_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [gkps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    gkps_pkg::gkps_cmd_t cmd;
    gkps_pkg::gkps_sts_t sts;

    // unpacked input fields
    logic [gkps_pkg::IDX_W-1:0]    in_index;
    logic [gkps_pkg::TSCORE_W-1:0] in_score;
    logic [gkps_pkg::BASE_W-1:0]   in_base;

    logic [gkps_pkg::POS_W-1:0]    out_position;
    logic [gkps_pkg::SCORE_W-1:0]  out_score;

    assign in_index = s_tdata[19:0];
    assign in_score = s_tdata[51:20];
    assign in_base  = s_tdata[54:52];

    // sequencer
    gkps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table, history, pending sums, output register
    gkps_dp #(
        .HALF_K   (HALF_K),
        .MAX_GAP  (MAX_GAP),
        .POS_BITS (POS_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .in_index     (in_index),
        .in_score     (in_score),
        .in_base      (in_base),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_position (out_position),
        .out_score    (out_score),
        .out_last     (m_tlast)
    );

    assign m_tdata = {out_score, out_position};

    // ------------------------------------------------------------ assertions
    // a new result never overwrites a word the receiver has not taken
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_load |-> sts.out_free)
        else $error("result loaded over a held output word");

    // an accepted base is always followed by the gap scan
    a_base_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.base_shift |=> cmd.scan_step)
        else $error("base accepted without a following scan");

    // no input word is taken while the table is still being zeroed
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_write |-> !s_tready)
        else $error("input ready during table clear");

endmodule

>>> tb/gapped_kmer_position_scorer_tb.sv
// ----------------------------------------------------------------------------
// gapped_kmer_position_scorer_tb
// Self-checking bench for the gapped k-mer position scorer. Table writes,
// base words and flushes are sent on the s_ stream. A predictor in the bench
// keeps its own score table, base history and pending sums, and works out the
// position words that each accepted input word must produce. A checker pops
// those words in order and compares them against the m_ stream. Gap settings
// are swept between sequences, including the extremes and an empty range.
// ----------------------------------------------------------------------------
module gapped_kmer_position_scorer_tb;

    // predictor geometry, mirrors the default block parameters
    localparam int HALF_K      = gkps_pkg::HALF_K_DEF;
    localparam int MAX_GAP     = gkps_pkg::MAX_GAP_DEF;
    localparam int KLEN        = 2 * HALF_K;
    localparam int HIST        = KLEN + MAX_GAP;
    localparam int DELAY       = HALF_K + (MAX_GAP + 1) / 2;
    localparam int TABLE_DEPTH = (MAX_GAP + 1) << (4 * HALF_K);

    typedef logic [gkps_pkg::OP_W-1:0]       op_t;
    typedef logic [gkps_pkg::IDX_W-1:0]      idx_t;
    typedef logic [gkps_pkg::TSCORE_W-1:0]   tscore_t;
    typedef logic [gkps_pkg::BASE_W-1:0]     base_t;
    typedef logic [gkps_pkg::CFG_DATA_W-1:0] gap_t;

    // op code the block must ignore
    localparam op_t OP_NONE = 2'd3;
    // base code of T, the highest real base
    localparam base_t BASE_T = 3'd3;

    localparam longint SUM_HI = 64'sd549755813887;
    localparam longint SUM_LO = -64'sd549755813888;

    // longest word is a flush; wait a bit longer before config
    localparam int IDLE_GUARD = 24;
    // post-reset table sweep covers all 589824 entries, the traffic adds far less
    localparam longint TIMEOUT_CYCLES = 2_000_000;

    // counted word target for the end of the run
    localparam int TOTAL_WORDS = 270;

    typedef struct packed {
        logic [gkps_pkg::POS_W-1:0]   pos;
        logic [gkps_pkg::SCORE_W-1:0] score;
        logic                         last;
    } scored_pos_t;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_tvalid;
    logic                                s_tready;
    // [19:0] table_index, [51:20] table_score, [54:52] base, [55] zero
    logic [gkps_pkg::S_TDATA_W-1:0]      s_tdata;
    // [1:0] op
    logic [gkps_pkg::OP_W-1:0]           s_tuser;
    logic                                m_tvalid;
    logic                                m_tready;
    // [31:0] position, [71:32] score
    logic [gkps_pkg::M_TDATA_W-1:0]      m_tdata;
    logic                                m_tlast;
    logic                                cfg_we;
    logic [gkps_pkg::CFG_ADDR_W-1:0]     cfg_addr;
    logic [gkps_pkg::CFG_DATA_W-1:0]     cfg_wdata;

    // predictor state
    tscore_t                     score_mem [int unsigned];
    base_t                       hist [HIST];
    longint                      pend [DELAY];
    logic [gkps_pkg::POS_W-1:0]  nbases;
    int                          fill_cnt;
    gap_t                        gap_min_r;
    gap_t                        gap_max_r;

    // position words still owed by the block, oldest first
    scored_pos_t             expected_scores [$];
    scored_pos_t             want;

    int                      mismatches;
    int                      words_counted;
    bit                      tx_idle_en;
    bit                      rx_stall_en;

    gapped_kmer_position_scorer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // drop everything tied to the current sequence; table and gaps stay
    function automatic void clear_sequence();
        int i;
        for (i = 0; i < HIST; i++) hist[i] = gkps_pkg::BASE_OTHER;
        for (i = 0; i < DELAY; i++) pend[i] = 0;
        nbases   = '0;
        fill_cnt = 0;
    endfunction

    function automatic longint clamp_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (s > SUM_HI) return SUM_HI;
        if (s < SUM_LO) return SUM_LO;
        return s;
    endfunction

    // update the model with one accepted word and queue what it emits
    function automatic void predict_scores(op_t op, idx_t idx, tscore_t tscore,
                                           base_t base);
        int          i, g, d, wlen, slot, gtop, m, t;
        logic [7:0]  lhalf, rhalf;
        logic        ok;
        int unsigned key;
        longint      tv;
        scored_pos_t sp;
        case (op)
            gkps_pkg::OP_WRITE: begin
                // writes past the last gap are dropped
                if (idx < TABLE_DEPTH) score_mem[idx] = tscore;
            end
            gkps_pkg::OP_BASE: begin
                for (i = HIST - 1; i > 0; i--) hist[i] = hist[i-1];
                hist[0] = base;
                for (i = 0; i < DELAY - 1; i++) pend[i] = pend[i+1];
                pend[DELAY-1] = 0;
                nbases = nbases + 1'b1;
                if (fill_cnt < HIST) fill_cnt++;
                gtop = (gap_max_r > MAX_GAP) ? MAX_GAP : int'(gap_max_r);
                for (g = int'(gap_min_r); g <= gtop; g++) begin
                    wlen = KLEN + g;
                    if (fill_cnt >= wlen) begin
                        ok    = 1'b1;
                        lhalf = '0;
                        rhalf = '0;
                        // oldest base of each half lands in the top bits
                        for (d = 0; d < HALF_K; d++) begin
                            if (hist[wlen-1-d] > BASE_T || hist[HALF_K-1-d] > BASE_T)
                                ok = 1'b0;
                            lhalf = {lhalf[5:0], hist[wlen-1-d][1:0]};
                            rhalf = {rhalf[5:0], hist[HALF_K-1-d][1:0]};
                        end
                        if (ok) begin
                            key  = (g << 16) | (lhalf << 8) | rhalf;
                            tv   = score_mem.exists(key) ? $signed(score_mem[key]) : 0;
                            slot = DELAY - (wlen + 1) / 2;
                            pend[slot] = clamp_sum(pend[slot], tv);
                        end
                    end
                end
                if (fill_cnt >= DELAY) begin
                    sp.pos   = nbases - DELAY;
                    sp.score = pend[0][gkps_pkg::SCORE_W-1:0];
                    sp.last  = 1'b0;
                    expected_scores.push_back(sp);
                end
            end
            gkps_pkg::OP_FLUSH: begin
                m = (fill_cnt < DELAY - 1) ? fill_cnt : DELAY - 1;
                for (t = 0; t < m; t++) begin
                    sp.pos   = nbases - m + t;
                    sp.score = pend[DELAY-m+t][gkps_pkg::SCORE_W-1:0];
                    sp.last  = (t == m - 1);
                    expected_scores.push_back(sp);
                end
                clear_sequence();
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // one word on the s_ stream, with an optional short gap in front
    task automatic send_word(input op_t op, input idx_t idx, input tscore_t tscore,
                             input base_t base);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, base, tscore, idx};
        do @(posedge aclk); while (!s_tready);
        predict_scores(op, idx, tscore, base);
        // every accepted word counts toward the run length
        words_counted++;
    endtask

    // stop sending, let every owed word arrive, then let the block settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_scores.size() != 0) @(posedge aclk);
        repeat (IDLE_GUARD) @(posedge aclk);
    endtask

    // only called with the block idle
    task automatic set_gaps(input gap_t gmin, input gap_t gmax);
        cfg_we    <= 1'b1;
        cfg_addr  <= gkps_pkg::CFG_GAP_MIN;
        cfg_wdata <= gmin;
        @(posedge aclk);
        cfg_addr  <= gkps_pkg::CFG_GAP_MAX;
        cfg_wdata <= gmax;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        gap_min_r = gmin;
        gap_max_r = gmax;
    endtask

    function automatic tscore_t pick_score();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // mostly full-depth sequences, now and then a short one
    function automatic int rand_seq_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 24);
    endfunction

    // fully random word: any op, any index, any base code
    task automatic send_noise();
        send_word(op_t'($urandom_range(0, 3)), idx_t'($urandom), $urandom,
                  base_t'($urandom));
    endtask

    // random sequence with table entries planted on some of its windows,
    // so lookups actually hit; sprinkled with noise, closed by a flush
    task automatic send_sequence(input int n);
        base_t             seq_b [$];
        int                i, p, np, g, wl, e, s0, d;
        logic [7:0]        lh, rh;
        for (i = 0; i < n; i++)
            seq_b.push_back(base_t'(($urandom_range(0, 11) == 0) ? $urandom_range(4, 7)
                                                                  : $urandom_range(0, 3)));
        np = $urandom_range(1, 4);
        for (p = 0; p < np; p++) begin
            g  = $urandom_range(0, MAX_GAP);
            wl = KLEN + g;
            if (n >= wl) begin
                e  = $urandom_range(wl - 1, n - 1);
                s0 = e - wl + 1;
                lh = '0;
                rh = '0;
                // non-ACGT codes alias onto A..T here, they must still miss
                for (d = 0; d < HALF_K; d++) begin
                    lh = {lh[5:0], seq_b[s0+d][1:0]};
                    rh = {rh[5:0], seq_b[e-HALF_K+1+d][1:0]};
                end
                send_word(gkps_pkg::OP_WRITE, {g[3:0], lh, rh}, pick_score(),
                          base_t'($urandom));
            end
        end
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_word(($urandom_range(0, 1) == 0) ? OP_NONE : gkps_pkg::OP_WRITE,
                          idx_t'($urandom), pick_score(), base_t'($urandom));
            send_word(gkps_pkg::OP_BASE, idx_t'($urandom), $urandom, seq_b[i]);
        end
        send_word(gkps_pkg::OP_FLUSH, idx_t'($urandom), $urandom, base_t'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // empty flush, ignored words, score extremes, gap 0 and gap 8 hits,
    // non-ACGT codes both in the gap and inside halves, partial flush
    task automatic test_directed();
        base_t             gap8_seq [16];
        int                i;
        gap8_seq = '{3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
                     3'd0, 3'd1, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3};
        send_word(gkps_pkg::OP_FLUSH, idx_t'($urandom), $urandom, base_t'($urandom));
        send_word(OP_NONE, idx_t'($urandom), $urandom, base_t'($urandom));
        send_word(gkps_pkg::OP_WRITE, 20'hF_FFFF, 32'h7FFF_FFFF, base_t'($urandom));
        // gap 0: ACGT|TTTT ends at the last base, max positive score
        send_word(gkps_pkg::OP_WRITE, 20'h0_1BFF, 32'h7FFF_FFFF, base_t'($urandom));
        // gap 8: TTTT|TTTT spans the whole sequence, most negative score
        send_word(gkps_pkg::OP_WRITE, 20'h8_FFFF, 32'h8000_0000, base_t'($urandom));
        for (i = 0; i < 16; i++)
            send_word(gkps_pkg::OP_BASE, idx_t'($urandom), $urandom, gap8_seq[i]);
        send_word(gkps_pkg::OP_FLUSH, idx_t'($urandom), $urandom, base_t'($urandom));
        // shorter than one delay: flush emits all three, last on the third
        for (i = 0; i < 3; i++)
            send_word(gkps_pkg::OP_BASE, idx_t'($urandom), $urandom,
                      base_t'($urandom_range(0, 3)));
        send_word(gkps_pkg::OP_FLUSH, idx_t'($urandom), $urandom, base_t'($urandom));
        drain_results();
    endtask

    // rotate gap settings, extremes and an empty range among them;
    // each switch waits until the block has gone quiet
    task automatic test_gap_sweep();
        int gmins [8];
        int gmaxs [8];
        int ph;
        gmins = '{0, 0, 8, 0, 5, 15, 2, 0};
        gmaxs = '{0, 8, 8, 15, 2, 15, 6, 9};
        for (ph = 0; ph < 8; ph++) begin
            set_gaps(gap_t'(gmins[ph]), gap_t'(gmaxs[ph]));
            send_sequence(rand_seq_len());
            if ($urandom_range(0, 2) == 0) send_noise();
            drain_results();
        end
    endtask

    // back-to-back traffic with both sides always ready
    task automatic test_streaming();
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        set_gaps(gkps_pkg::GAP_MIN_RST, gkps_pkg::GAP_MAX_RST);
        do
            send_sequence(rand_seq_len());
        while (words_counted < TOTAL_WORDS);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall bursts, then compare against the oldest
    // owed word
    // ------------------------------------------------------------------

    initial begin
        m_tready = 1'b1;
        forever begin
            @(posedge aclk);
            if (rx_stall_en && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_scores.size() == 0) begin
                $error("unexpected word: position %0d", m_tdata[31:0]);
                mismatches++;
            end else begin
                want = expected_scores.pop_front();
                if (m_tdata[31:0] !== want.pos) begin
                    $error("position: expected %0d, got %0d", want.pos, m_tdata[31:0]);
                    mismatches++;
                end
                if (m_tdata[71:32] !== want.score) begin
                    $error("score: expected %0d, got %0d",
                           $signed(want.score), $signed(m_tdata[71:32]));
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = gkps_pkg::OP_WRITE;
        cfg_we        = 1'b0;
        cfg_addr      = gkps_pkg::CFG_GAP_MIN;
        cfg_wdata     = '0;
        mismatches    = 0;
        words_counted = 0;
        tx_idle_en    = 1'b1;
        rx_stall_en   = 1'b1;
        gap_min_r     = gkps_pkg::GAP_MIN_RST;
        gap_max_r     = gkps_pkg::GAP_MAX_RST;
        clear_sequence();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        // s_tready stays low through the table clearing pass; send_word waits it out
        test_directed();
        test_gap_sweep();
        test_streaming();
        drain_results();
        if (mismatches == 0 && expected_scores.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hard stop if the stream hangs
    initial begin
        #(TIMEOUT_CYCLES * 20);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
